// ===== hw/rtl/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent/binormal block.
`default_nettype none
package ttb_pkg;

  localparam int unsigned DeltaW = 33;   // exact difference of two Q16.16 values
  localparam int unsigned CrossW = 67;   // exact x*y - z*w of two deltas
  localparam int unsigned NormTop = 29;  // top bit position after normalize shift
  localparam int unsigned OneQ14 = 16384;

  typedef logic signed [DeltaW-1:0] delta_t;

  typedef struct packed {
    delta_t e1x;
    delta_t e1y;
    delta_t e1z;
    delta_t e2x;
    delta_t e2y;
    delta_t e2z;
    delta_t du1;
    delta_t dv1;
    delta_t du2;
    delta_t dv2;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ttb_front.sv =====
// Vertex grouping: holds the first two corners and forms deltas on the third.
`default_nettype none
module ttb_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                mesh_start_i,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  input  wire logic signed [31:0]  tex_u_i,
  input  wire logic signed [31:0]  tex_v_i,
  output logic                     job_valid_o,
  output ttb_pkg::job_t            job_o
);
  import ttb_pkg::*;

  logic signed [31:0] px_q [2];
  logic signed [31:0] py_q [2];
  logic signed [31:0] pz_q [2];
  logic signed [31:0] tu_q [2];
  logic signed [31:0] tv_q [2];
  logic [1:0] count_q, count_d, cur;
  logic       third;

  function automatic delta_t dsub(logic signed [31:0] a, logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  assign cur   = mesh_start_i ? 2'd0 : count_q;
  assign third = cur[1];
  assign count_d = third ? 2'd0 : cur + 2'd1;
  assign job_valid_o = accept_i & third;

  always_comb begin
    job_o.e1x = dsub(px_q[1], px_q[0]);
    job_o.e1y = dsub(py_q[1], py_q[0]);
    job_o.e1z = dsub(pz_q[1], pz_q[0]);
    job_o.e2x = dsub(pos_x_i, px_q[0]);
    job_o.e2y = dsub(pos_y_i, py_q[0]);
    job_o.e2z = dsub(pos_z_i, pz_q[0]);
    job_o.du1 = dsub(tu_q[1], tu_q[0]);
    job_o.dv1 = dsub(tv_q[1], tv_q[0]);
    job_o.du2 = dsub(tex_u_i, tu_q[0]);
    job_o.dv2 = dsub(tex_v_i, tv_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      for (int i = 0; i < 2; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
        pz_q[i] <= '0;
        tu_q[i] <= '0;
        tv_q[i] <= '0;
      end
    end else if (accept_i) begin
      count_q <= count_d;
      if (!third) begin
        px_q[cur[0]] <= pos_x_i;
        py_q[cur[0]] <= pos_y_i;
        pz_q[cur[0]] <= pos_z_i;
        tu_q[cur[0]] <= tex_u_i;
        tv_q[cur[0]] <= tex_v_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ttb_jobq.sv =====
// Two-entry queue of triangle jobs between the front and the back.
`default_nettype none
module ttb_jobq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            enq_i,
  input  wire ttb_pkg::job_t   job_i,
  input  wire logic            deq_i,
  output logic                 full_o,
  output logic                 empty_o,
  output ttb_pkg::job_t        job_o
);
  import ttb_pkg::*;

  job_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq_i) wr_q <= ~wr_q;
      if (deq_i) rd_q <= ~rd_q;
      if (enq_i && !deq_i) cnt_q <= cnt_q + 2'd1;
      else if (!enq_i && deq_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ttb_back.sv =====
// Sequencer: cross products, normalize shift, square root and division per vector.
`default_nettype none
module ttb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire ttb_pkg::job_t   job_i,
  output logic                 deq_o,
  input  wire logic            pop_i,
  output logic                 out_valid_o,
  output logic signed [15:0]   tangent_x_o,
  output logic signed [15:0]   tangent_y_o,
  output logic signed [15:0]   tangent_z_o,
  output logic signed [15:0]   binormal_x_o,
  output logic signed [15:0]   binormal_y_o,
  output logic signed [15:0]   binormal_z_o,
  output logic                 degenerate_o
);
  import ttb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_NLOAD, ST_SHIFT, ST_SQ, ST_SQRT, ST_DINIT, ST_DIV, ST_DONE
  } state_e;

  state_e state_q;
  job_t   job_q;
  logic [3:0]  idx_q;
  logic        ph_q;
  logic        vec_q;
  logic [3:0]  cnt_q;
  logic signed [67:0]       prod_q;
  logic signed [CrossW-1:0] tmp_q;
  logic signed [CrossW-1:0] cross_q [7];
  logic [CrossW-1:0] a_q [3];
  logic [2:0]  neg_q;
  logic [63:0] s_q, r_q, bit_q;
  logic [44:0] n_q;
  logic [31:0] rem_q;
  logic [14:0] quo_q;
  logic signed [15:0] res_q [6];
  logic        bad_q, out_valid_q;

  logic signed [33:0] mul_a, mul_b;
  logic [CrossW-1:0] mag [3];
  logic [2:0]        mag_neg;
  logic [CrossW-1:0] or_all;
  logic [30:0]       len;
  logic [31:0]       rem2;
  logic              qbit;
  logic [14:0]       quo_d;
  logic [44:0]       num;
  logic [63:0]       trial;

  function automatic logic signed [33:0] sx(delta_t d);
    return {d[DeltaW-1], d};
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQ) begin
      mul_a = {4'b0, a_q[idx_q[1:0]][NormTop:0]};
      mul_b = mul_a;
    end else begin
      case (idx_q)
        4'd0:  begin mul_a = sx(job_q.du1); mul_b = sx(job_q.dv2); end
        4'd1:  begin mul_a = sx(job_q.du2); mul_b = sx(job_q.dv1); end
        4'd2:  begin mul_a = sx(job_q.dv2); mul_b = sx(job_q.e1x); end
        4'd3:  begin mul_a = sx(job_q.dv1); mul_b = sx(job_q.e2x); end
        4'd4:  begin mul_a = sx(job_q.dv2); mul_b = sx(job_q.e1y); end
        4'd5:  begin mul_a = sx(job_q.dv1); mul_b = sx(job_q.e2y); end
        4'd6:  begin mul_a = sx(job_q.dv2); mul_b = sx(job_q.e1z); end
        4'd7:  begin mul_a = sx(job_q.dv1); mul_b = sx(job_q.e2z); end
        4'd8:  begin mul_a = sx(job_q.du1); mul_b = sx(job_q.e2x); end
        4'd9:  begin mul_a = sx(job_q.du2); mul_b = sx(job_q.e1x); end
        4'd10: begin mul_a = sx(job_q.du1); mul_b = sx(job_q.e2y); end
        4'd11: begin mul_a = sx(job_q.du2); mul_b = sx(job_q.e1y); end
        4'd12: begin mul_a = sx(job_q.du1); mul_b = sx(job_q.e2z); end
        4'd13: begin mul_a = sx(job_q.du2); mul_b = sx(job_q.e1z); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Magnitudes of the selected vector; det sign folds into the component signs.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CrossW-1:0] c;
      c = vec_q ? cross_q[4+i] : cross_q[1+i];
      mag[i] = c[CrossW-1] ? CrossW'(-c) : c;
      mag_neg[i] = c[CrossW-1] ^ cross_q[0][CrossW-1];
    end
  end

  assign or_all = a_q[0] | a_q[1] | a_q[2];
  assign len    = r_q[30:0];
  assign trial  = r_q + bit_q;
  assign num    = {1'b0, a_q[idx_q[1:0]][NormTop:0], 14'b0} + 45'(len[30:1]);
  assign rem2   = {rem_q[30:0], n_q[14]};
  assign qbit   = (rem2 >= {1'b0, len});
  assign quo_d  = {quo_q[13:0], qbit};
  assign deq_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ph_q        <= 1'b0;
      vec_q       <= 1'b0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            job_q   <= job_i;
            idx_q   <= '0;
            ph_q    <= 1'b0;
            bad_q   <= 1'b0;
            vec_q   <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          ph_q <= ~ph_q;
          if (!ph_q) begin
            prod_q <= mul_a * mul_b;
          end else begin
            if (!idx_q[0]) tmp_q <= prod_q[CrossW-1:0];
            else cross_q[idx_q[3:1]] <= tmp_q - prod_q[CrossW-1:0];
            idx_q <= idx_q + 4'd1;
            if (idx_q == 4'd13) begin
              if (cross_q[0] == '0) begin
                bad_q   <= 1'b1;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_NLOAD;
              end
            end
          end
        end
        ST_NLOAD: begin
          for (int i = 0; i < 3; i++) a_q[i] <= mag[i];
          neg_q <= mag_neg;
          s_q   <= '0;
          idx_q <= '0;
          ph_q  <= 1'b0;
          if ((mag[0] | mag[1] | mag[2]) == '0) begin
            bad_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // truncating right shifts one bit at a time equal one larger shift
          if (|or_all[CrossW-1:NormTop+1]) begin
            for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
          end else if (!or_all[NormTop]) begin
            for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
          end else begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          ph_q <= ~ph_q;
          if (!ph_q) begin
            prod_q <= mul_a * mul_b;
          end else begin
            s_q   <= s_q + prod_q[63:0];
            idx_q <= idx_q + 4'd1;
            if (idx_q == 4'd2) begin
              r_q     <= '0;
              bit_q   <= 64'd1 << 62;
              state_q <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (s_q >= trial) begin
            s_q <= s_q - trial;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            idx_q   <= '0;
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          n_q     <= num;
          rem_q   <= {2'b0, num[44:15]};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= qbit ? rem2 - {1'b0, len} : rem2;
          quo_q <= quo_d;
          n_q   <= n_q << 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd14) begin
            res_q[(vec_q ? 3'd3 : 3'd0) + {1'b0, idx_q[1:0]}] <=
              neg_q[idx_q[1:0]] ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
            if (idx_q == 4'd2) begin
              if (!vec_q) begin
                vec_q   <= 1'b1;
                state_q <= ST_NLOAD;
              end else begin
                state_q <= ST_DONE;
              end
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= ST_DINIT;
            end
          end
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_valid_q) begin
            out_valid_q  <= 1'b1;
            tangent_x_o  <= bad_q ? '0 : res_q[0];
            tangent_y_o  <= bad_q ? '0 : res_q[1];
            tangent_z_o  <= bad_q ? '0 : res_q[2];
            binormal_x_o <= bad_q ? '0 : res_q[3];
            binormal_y_o <= bad_q ? '0 : res_q[4];
            binormal_z_o <= bad_q ? '0 : res_q[5];
            degenerate_o <= bad_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_tangent_binormal.sv =====
// Top level of the per-triangle tangent/binormal unit.
`default_nettype none
// Vertices (Q16.16 position and UV) enter through a push/full queue port; the
// first two of each triangle are only stored and produce nothing, and
// mesh_start_i restarts the grouping. The third vertex hands its edge and UV
// deltas to a two-entry job queue, so vertices keep flowing while a triangle
// is worked out; while that queue is full, full is high for every vertex. The
// back end runs one triangle at a time through a shared 34x34 multiplier
// (14 products), then per vector a normalize shift, three squares, a 32-step
// square root and three 15-step divisions with a setup step each. A triangle
// ends early, flagged degenerate, when the UV determinant, the tangent or the
// binormal is zero.
// Results (Q2.14 unit tangent and binormal, degenerate flag) wait in an
// output register read through empty/pop.
module triangle_tangent_binormal (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               mesh_start_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] tex_u_i,
  input  wire logic signed [31:0] tex_v_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      tangent_x_o,
  output logic signed [15:0]      tangent_y_o,
  output logic signed [15:0]      tangent_z_o,
  output logic signed [15:0]      binormal_x_o,
  output logic signed [15:0]      binormal_y_o,
  output logic signed [15:0]      binormal_z_o,
  output logic                    degenerate_o
);
  import ttb_pkg::*;

  logic accept, job_valid, q_full, q_empty, deq, out_valid;
  job_t job_in, job_head;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign empty  = ~out_valid;

  ttb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mesh_start_i (mesh_start_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .job_valid_o  (job_valid),
    .job_o        (job_in)
  );

  ttb_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (job_valid),
    .job_i   (job_in),
    .deq_i   (deq),
    .full_o  (q_full),
    .empty_o (q_empty),
    .job_o   (job_head)
  );

  ttb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .job_i        (job_head),
    .deq_o        (deq),
    .pop_i        (pop),
    .out_valid_o  (out_valid),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .binormal_x_o (binormal_x_o),
    .binormal_y_o (binormal_y_o),
    .binormal_z_o (binormal_z_o),
    .degenerate_o (degenerate_o)
  );

endmodule
`default_nettype wire
